// File: design/isa_bms_pkg.sv
// shared types, constants and helpers for the isa bus master sequencer
package isa_bms_pkg;

	localparam int ADDR_W    = 20;
	localparam int HIGH_W    = ADDR_W - 8;
	localparam int QDEPTH    = 2;
	localparam int QAW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int BITCNT_W  = $clog2(HIGH_W + 1);
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] FN_IO_WR  = 2'd0;
	localparam logic [1:0] FN_IO_RD  = 2'd1;
	localparam logic [1:0] FN_MEM_WR = 2'd2;
	localparam logic [1:0] FN_MEM_RD = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IOW_SETUP  = 3'd0,
		CFG_IOW_STROBE = 3'd1,
		CFG_SETUP_HOLD = 3'd2,
		CFG_STROBE     = 3'd3,
		CFG_SAMPLE     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
		logic [7:0]        bus_data_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic [7:0]        low_address_pins;
		logic [HIGH_W-1:0] high_address_out;
		logic              shift_done;
		logic [7:0]        data_pins_out;
		logic [1:0]        strobe_line;
	} out_word_t;

	// classified access as it sits in the queue
	typedef struct packed {
		logic [1:0]        func;
		logic              is_read;
		logic              is_io_wr;
		logic [7:0]        low;
		logic [HIGH_W-1:0] high;
		logic [7:0]        rdata;
		logic [7:0]        wdata;
	} job_t;

	typedef struct packed {
		logic [7:0] io_write_setup_cycles;
		logic [7:0] io_write_strobe_cycles;
		logic [7:0] setup_hold_cycles;
		logic [7:0] strobe_cycles;
		logic [7:0] sample_delay_cycles;
	} cfg_t;

	typedef struct packed {
		logic [QAW:0] count;
	} q_stat_t;

	typedef struct packed {
		logic busy;
		logic cache_valid;
	} back_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SHIFT,
		BK_LATCH,
		BK_SETUP,
		BK_STROBE,
		BK_HOLD,
		BK_DONE
	} back_state_t;

	// data pins are wired in reverse bit order
	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

endpackage

// File: design/isa_bms_front.sv
// front end: accepts access words, classifies them and stages them for the queue
module isa_bms_front import isa_bms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_word_t in_word,
	output logic     job_valid,
	input  logic     job_ready,
	output job_t     job
);

	logic valid_s1;
	job_t job_s1;
	job_t job_d;

	always_comb begin
		job_d.func     = in_word.func;
		job_d.is_read  = in_word.func[0];
		job_d.is_io_wr = (in_word.func == FN_IO_WR);
		job_d.low      = in_word.address[7:0];
		job_d.high     = in_word.address[ADDR_W-1:8];
		job_d.rdata    = in_word.func[0] ? flip8(in_word.bus_data_in) : 8'd0;
		job_d.wdata    = in_word.func[0] ? 8'd0 : flip8(in_word.write_data);
	end

	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule

// File: design/isa_bms_queue.sv
// short fifo between front and back
module isa_bms_queue import isa_bms_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  job_t    push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output job_t    pop_data,
	output q_stat_t stat
);

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;

	assign push_ready = (count_q != (QAW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.count = count_q;

	function automatic logic [QAW-1:0] wrap_inc(input logic [QAW-1:0] p);
		return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: design/isa_bms_back.sv
// back end: high address shift, strobe timing and result register
module isa_bms_back import isa_bms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  job_t       pop_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_word_t  out_word,
	output back_stat_t stat
);

	back_state_t       state_q, state_d;
	job_t              cur_q;
	logic [HIGH_W-1:0] cached_q;
	logic              cache_valid_q;
	logic              shift_q;
	logic [HIGH_W-1:0] sh_q;
	logic [HIGH_W-1:0] acc_q;
	logic [BITCNT_W-1:0] bitcnt_q;
	logic [7:0]        cnt_q;
	logic [7:0]        elapsed_q;
	logic              sampled_q;
	logic [7:0]        rd_q;
	logic              out_valid_q;
	out_word_t         out_q;
	logic              shift_need;
	logic              out_free;
	logic              pop;
	logic              sel_io_wr;
	logic [7:0]        setup_val;
	logic [7:0]        strobe_val;

	assign shift_need = !cache_valid_q || (pop_data.high != cached_q);
	assign out_free   = !out_valid_q || out_ready;
	assign pop        = pop_valid && pop_ready;
	// in idle the setup count is loaded for the word being popped
	assign sel_io_wr  = (state_q == BK_IDLE) ? pop_data.is_io_wr : cur_q.is_io_wr;
	assign setup_val  = sel_io_wr ? cfg.io_write_setup_cycles : cfg.setup_hold_cycles;
	assign strobe_val = cur_q.is_io_wr ? cfg.io_write_strobe_cycles : cfg.strobe_cycles;

	assign out_valid        = out_valid_q;
	assign out_word         = out_q;
	assign stat.busy        = (state_q != BK_IDLE);
	assign stat.cache_valid = cache_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = shift_need ? BK_SHIFT : BK_SETUP;
				end
			end
			BK_SHIFT: begin
				if (bitcnt_q == BITCNT_W'(HIGH_W - 1)) begin
					state_d = BK_LATCH;
				end
			end
			BK_LATCH: state_d = BK_SETUP;
			BK_SETUP: begin
				if (cnt_q == '0) begin
					state_d = BK_STROBE;
				end
			end
			BK_STROBE: begin
				if (cnt_q == '0) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (cnt_q == '0) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// high address cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_q      <= '0;
			cache_valid_q <= 1'b0;
		end else if (pop && shift_need) begin
			cached_q      <= pop_data.high;
			cache_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == BK_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q    <= pop_data;
			shift_q  <= shift_need;
			sh_q     <= pop_data.high;
			acc_q    <= '0;
			bitcnt_q <= '0;
			rd_q     <= '0;
		end
		// serial shift, msb first; acc collects what went out
		if (state_q == BK_SHIFT) begin
			acc_q    <= (acc_q << 1) | HIGH_W'(sh_q[HIGH_W-1]);
			sh_q     <= sh_q << 1;
			bitcnt_q <= bitcnt_q + 1'b1;
		end
		if (state_q != state_d) begin
			case (state_d)
				BK_SETUP:  cnt_q <= setup_val;
				BK_STROBE: begin
					cnt_q     <= (strobe_val == '0) ? '0 : strobe_val - 1'b1;
					elapsed_q <= '0;
					sampled_q <= 1'b0;
				end
				BK_HOLD:   cnt_q <= setup_val;
				default:   cnt_q <= cnt_q;
			endcase
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
		if (state_q == BK_STROBE) begin
			elapsed_q <= elapsed_q + 1'b1;
			// read data is taken at the sample point, or at strobe end at the latest
			if (cur_q.is_read && !sampled_q
					&& (elapsed_q == cfg.sample_delay_cycles || cnt_q == '0)) begin
				rd_q      <= cur_q.rdata;
				sampled_q <= 1'b1;
			end
		end
		if (state_q == BK_DONE && out_free) begin
			out_q.read_data        <= rd_q;
			out_q.low_address_pins <= cur_q.low;
			out_q.high_address_out <= shift_q ? acc_q : '0;
			out_q.shift_done       <= shift_q;
			out_q.data_pins_out    <= cur_q.wdata;
			out_q.strobe_line      <= cur_q.func;
		end
	end

endmodule

// File: design/isa_bus_master_sequencer.sv
// top level of the 8-bit isa bus master sequencer
//
// in_valid/in_ready/in_word carry one bus access per word: func, address,
// write byte and the raw data pins seen during a read strobe. out_valid,
// out_ready and out_word return one result word per access, in order.
// cfg_we/cfg_idx/cfg_wdata write the five timing registers; writes to an
// unused index are dropped. write them only while the block is idle.
// a front stage and a two-entry queue take new words while the back end
// is busy with the current access and while a result waits to be taken.
// in the back end an access runs through shift and latch of the upper
// address, only when it differs from the cached one or the cache is
// invalid, then through setup, strobe, hold and done; the timing
// registers set the length of setup, strobe and hold, and only one access
// is in the back end at a time. reset clears the queue, the result valid
// flag and the address cache, so the first access always shifts; timing
// registers return to their defaults. a stalled receiver holds the
// result; the back end then waits at its last step and the queue fills
// before in_ready drops.
module isa_bus_master_sequencer import isa_bms_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_word,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]           cfg_wdata
);

	cfg_t       cfg_q;
	logic       job_valid;
	logic       job_ready;
	job_t       job;
	logic       pop_valid;
	logic       pop_ready;
	job_t       pop_data;
	q_stat_t    q_stat;
	back_stat_t b_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.io_write_setup_cycles  <= 8'd8;
			cfg_q.io_write_strobe_cycles <= 8'd40;
			cfg_q.setup_hold_cycles      <= 8'd4;
			cfg_q.strobe_cycles          <= 8'd20;
			cfg_q.sample_delay_cycles    <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IOW_SETUP:  cfg_q.io_write_setup_cycles  <= cfg_wdata;
				CFG_IOW_STROBE: cfg_q.io_write_strobe_cycles <= cfg_wdata;
				CFG_SETUP_HOLD: cfg_q.setup_hold_cycles      <= cfg_wdata;
				CFG_STROBE:     cfg_q.strobe_cycles          <= cfg_wdata;
				CFG_SAMPLE:     cfg_q.sample_delay_cycles    <= cfg_wdata;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	isa_bms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	isa_bms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.stat       (q_stat)
	);

	isa_bms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.stat      (b_stat)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= (QAW+1)'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_shift_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.shift_done |-> out_word.high_address_out == '0)
		else $error("high address reported without a shift");

	a_write_no_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.strobe_line[0] |-> out_word.read_data == 8'd0)
		else $error("write access returned read data");

	a_result_sets_cache: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> b_stat.cache_valid)
		else $error("result without a valid address cache");

	a_idle_takes_words: assert property (@(posedge clk) disable iff (!arst_n)
		!b_stat.busy |-> pop_ready)
		else $error("idle back end refused the queue");

endmodule
